@@ hdl/mas_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mas_pkg
// Shared constants, codes and control structs of the 4x4 matrix unit.
// ----------------------------------------------------------------------------
package mas_pkg;

  localparam int DIM       = 4;
  localparam int NELEM     = DIM * DIM;
  localparam int DIM_W     = $clog2(DIM);
  localparam int ADDR_W    = $clog2(NELEM);
  localparam int CMD_W     = 3;
  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * WORD_W;
  // four truncated products of PROD_W-FRAC_BITS bits summed exactly
  localparam int ACC_W     = PROD_W - FRAC_BITS + DIM_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 3'd0,
    CMD_LOAD_B = 3'd1,
    CMD_MUL    = 3'd2,
    CMD_ADD    = 3'd3,
    CMD_SCALE  = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic              issue;
    cmd_t              op;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] idx;
    logic              first;
    logic              emit;
    logic              last;
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              ld_scalar;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic adv;
  } dp_sts_t;

  // control that travels along the datapath stages
  typedef struct packed {
    logic              valid;
    cmd_t              op;
    logic [ADDR_W-1:0] idx;
    logic              first;
    logic              emit;
    logic              last;
  } pipe_ctl_t;

endpackage
`default_nettype wire

@@ hdl/mas_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/mas_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mas_ctrl
// Command decode and element/term sequencer of the matrix unit.
// ----------------------------------------------------------------------------
module mas_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [mas_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [mas_pkg::ADDR_W-1:0]    in_idx,
  output      mas_pkg::dp_cmd_t              cmd,
  input  wire mas_pkg::dp_sts_t              sts
);

  mas_pkg::state_t              state, state_next;
  mas_pkg::cmd_t                op, op_next;
  logic [mas_pkg::ADDR_W-1:0]   elem, elem_next;
  logic [mas_pkg::DIM_W-1:0]    k, k_next;
  logic                         mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mas_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    op   <= op_next;
    elem <= elem_next;
    k    <= k_next;
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    elem_next   = elem;
    k_next      = k;
    cmd         = '0;
    cmd.op      = op;
    cmd.wr_addr = in_idx;
    // a new command waits until the pipeline moves, so the scalar of a
    // stalled scale element is not overwritten
    in_ready    = (state == mas_pkg::ST_IDLE) && sts.adv;
    mul         = (op == mas_pkg::CMD_MUL);
    unique case (state)
      mas_pkg::ST_IDLE: begin
        if (in_valid && sts.adv) begin
          unique case (in_cmd)
            mas_pkg::CMD_LOAD_A: cmd.wr_a = 1'b1;
            mas_pkg::CMD_LOAD_B: cmd.wr_b = 1'b1;
            mas_pkg::CMD_MUL, mas_pkg::CMD_ADD, mas_pkg::CMD_SCALE: begin
              op_next       = mas_pkg::cmd_t'(in_cmd);
              state_next    = mas_pkg::ST_RUN;
              elem_next     = '0;
              k_next        = '0;
              cmd.ld_scalar = 1'b1;
            end
            default: ;
          endcase
        end
      end
      mas_pkg::ST_RUN: begin
        if (sts.adv) begin
          cmd.issue  = 1'b1;
          // product reads row r of A and column c of B, one term per cycle while the pipeline advances
          cmd.addr_a = mul ? {k, elem[mas_pkg::DIM_W-1:0]} : elem;
          cmd.addr_b = mul ? {elem[mas_pkg::ADDR_W-1:mas_pkg::DIM_W], k} : elem;
          cmd.idx    = elem;
          cmd.first  = !mul || (k == '0);
          cmd.emit   = !mul || (k == mas_pkg::DIM_W'(mas_pkg::DIM - 1));
          cmd.last   = cmd.emit && (elem == mas_pkg::ADDR_W'(mas_pkg::NELEM - 1));
          if (cmd.emit) begin
            elem_next = elem + 1'b1;
            k_next    = '0;
            if (cmd.last) begin
              state_next = mas_pkg::ST_IDLE;
            end
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/mas_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mas_dpath
// Matrix stores, multiplier, accumulator and saturating output register.
// ----------------------------------------------------------------------------
module mas_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mas_pkg::dp_cmd_t              cmd,
  output      mas_pkg::dp_sts_t              sts,
  input  wire logic [mas_pkg::WORD_W-1:0]    in_value,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [mas_pkg::ADDR_W-1:0]    out_idx,
  output      logic [mas_pkg::WORD_W-1:0]    out_value,
  output      logic                          out_ovf,
  output      logic                          out_last
);

  localparam int TERM_W = mas_pkg::PROD_W - mas_pkg::FRAC_BITS;
  localparam int HEAD_W = mas_pkg::ACC_W - mas_pkg::WORD_W + 1;

  logic                              adv;
  logic [mas_pkg::WORD_W-1:0]        rd_a, rd_b, scalar;
  logic signed [mas_pkg::WORD_W-1:0] op_a, op_b;
  logic signed [mas_pkg::PROD_W-1:0] prod, prod_mul;
  logic signed [mas_pkg::WORD_W:0]   sum_ab;
  logic signed [mas_pkg::ACC_W-1:0]  acc, term;
  logic [HEAD_W-1:0]                 head;
  logic                              sat;
  mas_pkg::pipe_ctl_t                s1, s2, s3;

  // whole pipeline moves only when the output register can take a value
  assign adv     = !out_valid || out_ready;
  assign sts.adv = adv;

  mas_ram #(.WIDTH(mas_pkg::WORD_W), .DEPTH(mas_pkg::NELEM)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .waddr (cmd.wr_addr),
    .wdata (in_value),
    .re    (adv),
    .raddr (cmd.addr_a),
    .rdata (rd_a)
  );

  mas_ram #(.WIDTH(mas_pkg::WORD_W), .DEPTH(mas_pkg::NELEM)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .waddr (cmd.wr_addr),
    .wdata (in_value),
    .re    (adv),
    .raddr (cmd.addr_b),
    .rdata (rd_b)
  );

  assign op_a     = $signed(rd_a);
  assign op_b     = (s1.op == mas_pkg::CMD_SCALE) ? $signed(scalar) : $signed(rd_b);
  assign prod_mul = op_a * op_b;
  assign sum_ab   = $signed({rd_a[mas_pkg::WORD_W-1], rd_a})
                  + $signed({rd_b[mas_pkg::WORD_W-1], rd_b});

  // truncate products toward minus infinity, sums pass as they are
  assign term = (s2.op == mas_pkg::CMD_ADD) ? prod[mas_pkg::ACC_W-1:0] :
    {{(mas_pkg::ACC_W - TERM_W){prod[mas_pkg::PROD_W-1]}},
     prod[mas_pkg::PROD_W-1:mas_pkg::FRAC_BITS]};

  assign head = acc[mas_pkg::ACC_W-1:mas_pkg::WORD_W-1];
  assign sat  = !((&head) || !(|head));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid  <= 1'b0;
      s2.valid  <= 1'b0;
      s3.valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1.valid  <= cmd.issue;
      s2.valid  <= s1.valid;
      s3.valid  <= s2.valid;
      out_valid <= s3.valid && s3.emit;
      s1.op    <= cmd.op;
      s1.idx   <= cmd.idx;
      s1.first <= cmd.first;
      s1.emit  <= cmd.emit;
      s1.last  <= cmd.last;
      s2.op    <= s1.op;
      s2.idx   <= s1.idx;
      s2.first <= s1.first;
      s2.emit  <= s1.emit;
      s2.last  <= s1.last;
      s3.op    <= s2.op;
      s3.idx   <= s2.idx;
      s3.first <= s2.first;
      s3.emit  <= s2.emit;
      s3.last  <= s2.last;
      if (s1.op == mas_pkg::CMD_ADD) begin
        prod <= {{(mas_pkg::PROD_W - mas_pkg::WORD_W - 1){sum_ab[mas_pkg::WORD_W]}},
                 sum_ab};
      end else begin
        prod <= prod_mul;
      end
      if (s2.valid) begin
        acc <= s2.first ? term : acc + term;
      end
      out_idx  <= s3.idx;
      out_last <= s3.last;
      out_ovf  <= sat;
      if (sat) begin
        out_value <= acc[mas_pkg::ACC_W-1] ?
          {1'b1, {(mas_pkg::WORD_W-1){1'b0}}} : {1'b0, {(mas_pkg::WORD_W-1){1'b1}}};
      end else begin
        out_value <= acc[mas_pkg::WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_scalar) begin
      scalar <= in_value;
    end
  end

endmodule
`default_nettype wire

@@ hdl/mat4_multiply_add_scale_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mat4_multiply_add_scale_unit
// 4x4 Q16.16 matrix unit: loads A and B, emits A*B, A+B or A scaled.
// ----------------------------------------------------------------------------
// usage
//   s_* carries commands: tuser = command, tdata = element_index, value.
//   loads write one element of A or B and give no result; the unused
//   command codes are taken as well and dropped.
//   multiply, add and scale stream sixteen results on m_* in column-major
//   order, tlast on the sixteenth; tuser flags a saturated element.
//   add and scale issue one element a cycle and multiply runs one
//   multiply-accumulate per cycle through a single 32x32 multiplier, four
//   per element, both only while the pipeline is not stalled.
//   each element passes the RAM read, product, accumulate and output
//   registers in turn; the next command is taken once the controller is
//   back in idle after issuing the last element, while results still drain.
//   a stall on m_tready freezes the whole pipeline and holds s_tready low
//   while a result waits; nothing is lost.
//   rst clears control only; matrix elements are undefined until loaded.
// ----------------------------------------------------------------------------
module mat4_multiply_add_scale_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [39:0] s_tdata,   // element_index[3:0], value[35:4], zero pad
  input  wire logic [2:0]  s_tuser,   // command[2:0]
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata,   // result_index[3:0], result_value[35:4], zero pad
  output      logic [0:0]  m_tuser,   // overflow[0]
  output      logic        m_tlast
);

  mas_pkg::dp_cmd_t               cmd;
  mas_pkg::dp_sts_t               sts;
  logic [mas_pkg::ADDR_W-1:0]     out_idx;
  logic [mas_pkg::WORD_W-1:0]     out_value;
  logic                           out_ovf;

  mas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .in_idx   (s_tdata[3:0]),
    .cmd      (cmd),
    .sts      (sts)
  );

  mas_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_value  (s_tdata[35:4]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_idx   (out_idx),
    .out_value (out_value),
    .out_ovf   (out_ovf),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0000, out_value, out_idx};
  assign m_tuser = out_ovf;

  a_issue_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> sts.adv)
    else $error("element issued while pipeline stalled");

  a_no_accept_while_run: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !cmd.issue)
    else $error("command taken while elements are still being issued");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[3:0] == 4'hf))
    else $error("last marked on an element other than the final one");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tdata[35:4] == 32'h7fffffff || m_tdata[35:4] == 32'h80000000))
    else $error("overflow flagged on an unclamped value");

endmodule
`default_nettype wire
